[rtl/rsl_pkg.sv]
// Shared types, constants and register codes of the tachometer shift light bar.
// No dependencies; every other file of the block imports this package.
package rsl_pkg;

   localparam int PIXEL_COUNT = 15;
   localparam int PIX_W       = $clog2(PIXEL_COUNT);
   localparam int RPM_W       = 16;
   localparam int LEVEL_W     = 8;
   localparam int STAGE_W     = 4;
   localparam int MODE_W      = 2;
   // thresholds reach down to -14 * 65535, so 21 bits signed plus margin
   localparam int THR_W       = 22;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;

   // stage layout of the quantised modes
   localparam int SIDE_STAGE_TOP  = 9;
   localparam int SIDE_BASE_K     = SIDE_STAGE_TOP - 1;
   localparam int SHORT_STAGE_TOP = 4;
   localparam int SHORT_BASE_K    = SHORT_STAGE_TOP - 1;
   localparam logic [STAGE_W-1:0] LIT_ALL_BLUE = STAGE_W'(SIDE_STAGE_TOP);
   localparam logic [STAGE_W-1:0] LIT_SHORT_1  = STAGE_W'(3);
   localparam logic [STAGE_W-1:0] LIT_SHORT_2  = STAGE_W'(6);
   localparam logic [STAGE_W-1:0] LIT_SHORT_3  = STAGE_W'(8);

   // colour bands
   localparam int BAR_GREEN_LAST   = 9;
   localparam int BAR_YELLOW_LAST  = 12;
   localparam int SIDE_GREEN_LAST  = 2;
   localparam int SIDE_YELLOW_LAST = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_LEFT_RIGHT  = 2'd0,
      MODE_SIDE_FILL   = 2'd1,
      MODE_SIDE_SHORT  = 2'd2,
      MODE_SHIFT_LIGHT = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHIFT_RPM        = 3'd0,
      CSR_STEP_RPM         = 3'd1,
      CSR_DISPLAY_MODE     = 3'd2,
      CSR_GREEN_LEVEL      = 3'd3,
      CSR_YELLOW_RED_LEVEL = 3'd4,
      CSR_RED_LEVEL        = 3'd5,
      CSR_BLUE_LEVEL       = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [RPM_W-1:0]   shift_rpm;
      logic [RPM_W-1:0]   step_rpm;
      mode_type           display_mode;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] yellow_red_level;
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] blue_level;
   } cfg_type;

   // one frame order handed from the front to the back
   typedef struct packed {
      logic                   bar_mode;  // left to right: use mask
      logic [PIXEL_COUNT-1:0] mask;
      logic [STAGE_W-1:0]     lit;       // pixels lit from each end, 9 = all blue
      logic [STAGE_W-1:0]     stage;
   } entry_type;

   typedef struct packed {
      logic [PIX_W-1:0]   index;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [STAGE_W-1:0] stage;
      logic               last;
   } pixel_type;

endpackage

[rtl/rpm_shift_light_bar.sv]
// Tachometer bar graph and shift light for a 15 pixel strip.
// A sample that produces a frame is written into the frame queue when accepted; a frame
// is 15 pixel transactions, and the back end emits one pixel per cycle while pop is high;
// samples that produce no frame are accepted whenever the queue has room.
// Reset (synchronous, active high): registers to defaults, shown stage 0, queue empty.
// Depends on rsl_pkg, rsl_front, rsl_queue and rsl_back.
module rpm_shift_light_bar (
   input  logic                             clock,
   input  logic                             reset,
   // sample channel
   input  logic                             push,
   output logic                             full,
   input  logic [rsl_pkg::RPM_W-1:0]        req_rpm,
   // pixel channel
   output logic                             empty,
   input  logic                             pop,
   output logic [rsl_pkg::PIX_W-1:0]        rsp_pixel_index,
   output logic [rsl_pkg::LEVEL_W-1:0]      rsp_red,
   output logic [rsl_pkg::LEVEL_W-1:0]      rsp_green,
   output logic [rsl_pkg::LEVEL_W-1:0]      rsp_blue,
   output logic [rsl_pkg::STAGE_W-1:0]      rsp_stage,
   output logic                             rsp_last_pixel,
   // register write port
   input  logic                             csr_we,
   input  logic [rsl_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rsl_pkg::CSR_DATA_W-1:0]   csr_data
);
   import rsl_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type front_entry;
   entry_type head;
   logic      accept;
   logic      emit;
   logic      frame_done;
   pixel_type pixel;

   // Register file: take a write whenever the enable is high, drop unknown indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SHIFT_RPM:        cfg_in.shift_rpm        = csr_data;
            CSR_STEP_RPM:         cfg_in.step_rpm         = csr_data;
            CSR_DISPLAY_MODE:     cfg_in.display_mode     = mode_type'(csr_data[MODE_W-1:0]);
            CSR_GREEN_LEVEL:      cfg_in.green_level      = csr_data[LEVEL_W-1:0];
            CSR_YELLOW_RED_LEVEL: cfg_in.yellow_red_level = csr_data[LEVEL_W-1:0];
            CSR_RED_LEVEL:        cfg_in.red_level        = csr_data[LEVEL_W-1:0];
            CSR_BLUE_LEVEL:       cfg_in.blue_level       = csr_data[LEVEL_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shift_rpm        <= RPM_W'(5500);
         cfg_ff.step_rpm         <= RPM_W'(300);
         cfg_ff.display_mode     <= MODE_SIDE_FILL;
         cfg_ff.green_level      <= '1;
         cfg_ff.yellow_red_level <= '1;
         cfg_ff.red_level        <= '1;
         cfg_ff.blue_level       <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A sample is taken whenever the queue has room; it queues a frame only if one is due.
   assign accept = push && !full;

   rsl_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .rpm    (req_rpm),
      .accept (accept),
      .emit   (emit),
      .entry  (front_entry)
   );

   // Hold pending frames here so the front keeps taking samples while a frame drains.
   rsl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && emit),
      .push_entry (front_entry),
      .pop        (frame_done),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   // Advance one pixel per pixel transaction; retire the frame after its last pixel.
   rsl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .head_valid (!empty),
      .pop        (pop),
      .pixel      (pixel),
      .frame_done (frame_done)
   );

   assign rsp_pixel_index = pixel.index;
   assign rsp_red         = pixel.red;
   assign rsp_green       = pixel.green;
   assign rsp_blue        = pixel.blue;
   assign rsp_stage       = pixel.stage;
   assign rsp_last_pixel  = pixel.last;

   // Within a frame, every pixel transaction but the last is followed by the next pixel.
   a_frame_continues: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_pixel) |=>
         (!empty && rsp_pixel_index == $past(rsp_pixel_index) + PIX_W'(1)))
      else $error("frame broke off before its last pixel");

   // A left to right sample always queues a frame.
   a_bar_emits: assert property (@(posedge clock) disable iff (reset)
      (push && !full && cfg_ff.display_mode == MODE_LEFT_RIGHT) |=> !empty)
      else $error("left to right sample produced no frame");

   // The last pixel flag marks exactly the final pixel position.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_last_pixel == (rsp_pixel_index == PIX_W'(PIXEL_COUNT-1))))
      else $error("last pixel flag out of step with pixel index");

endmodule

[rtl/rsl_front.sv]
// Front end: compares a speed sample against the bar thresholds and builds a frame order.
// Holds the shown stage register. Depends on rsl_pkg.
module rsl_front (
   input  logic                             clock,
   input  logic                             reset,
   input  rsl_pkg::cfg_type                 cfg,
   input  logic [rsl_pkg::RPM_W-1:0]        rpm,
   input  logic                             accept,
   output logic                             emit,
   output rsl_pkg::entry_type               entry
);
   import rsl_pkg::*;

   logic signed [THR_W-1:0] rpm_s;
   logic signed [THR_W-1:0] thr [PIXEL_COUNT];
   logic [PIXEL_COUNT-1:0]  gt;
   logic [PIXEL_COUNT-1:0]  lt;
   logic [STAGE_W-1:0]      stage;
   logic [STAGE_W-1:0]      lit;
   logic [STAGE_W-1:0]      shown_stage_ff;
   logic [STAGE_W-1:0]      shown_stage_in;

   // thresholds T(k) = shift - k * step, each against the sample in parallel
   always_comb begin
      rpm_s = signed'({{(THR_W-RPM_W){1'b0}}, rpm});
      for (int k = 0; k < PIXEL_COUNT; k++) begin
         thr[k] = signed'(THR_W'(cfg.shift_rpm))
                - signed'(THR_W'(cfg.step_rpm) * THR_W'(k));
         gt[k]  = rpm_s > thr[k];
         lt[k]  = rpm_s < thr[k];
      end
   end

   always_comb begin
      stage = '0;
      lit   = '0;
      case (cfg.display_mode)
         MODE_SIDE_FILL: begin
            if (gt[SIDE_BASE_K]) begin
               stage = STAGE_W'(SIDE_STAGE_TOP);
               for (int s = SIDE_BASE_K; s >= 1; s--) begin
                  if (lt[SIDE_BASE_K-s]) stage = STAGE_W'(s);
               end
            end
            lit = stage;
         end
         MODE_SIDE_SHORT: begin
            if (gt[SHORT_BASE_K]) begin
               stage = STAGE_W'(SHORT_STAGE_TOP);
               for (int s = SHORT_BASE_K; s >= 1; s--) begin
                  if (lt[SHORT_BASE_K-s]) stage = STAGE_W'(s);
               end
            end
            case (stage)
               STAGE_W'(1): lit = LIT_SHORT_1;
               STAGE_W'(2): lit = LIT_SHORT_2;
               STAGE_W'(3): lit = LIT_SHORT_3;
               STAGE_W'(SHORT_STAGE_TOP): lit = LIT_ALL_BLUE;
               default: lit = '0;
            endcase
         end
         MODE_SHIFT_LIGHT: begin
            stage = STAGE_W'(gt[0]);
            lit   = gt[0] ? LIT_ALL_BLUE : '0;
         end
         default: begin
            stage = '0;
            lit   = '0;
         end
      endcase
   end

   always_comb begin
      emit           = (cfg.display_mode == MODE_LEFT_RIGHT) || (stage != shown_stage_ff);
      shown_stage_in = shown_stage_ff;
      if (accept && cfg.display_mode != MODE_LEFT_RIGHT) shown_stage_in = stage;
      entry.bar_mode = cfg.display_mode == MODE_LEFT_RIGHT;
      for (int i = 0; i < PIXEL_COUNT; i++) entry.mask[i] = gt[PIXEL_COUNT-1-i];
      entry.lit      = lit;
      entry.stage    = stage;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_stage_ff <= '0;
      end else begin
         shown_stage_ff <= shown_stage_in;
      end
   end

endmodule

[rtl/rsl_queue.sv]
// Short queue of frame orders between the front and the back.
// Depends on rsl_pkg for the entry type and depth.
module rsl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rsl_pkg::entry_type push_entry,
   input  logic               pop,
   output rsl_pkg::entry_type head,
   output logic               full,
   output logic               empty
);
   import rsl_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full      = count_ff == CNT_W'(QUEUE_DEPTH);
      empty     = count_ff == '0;
      do_push   = push && !full;
      do_pop    = pop && !empty;
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

[rtl/rsl_back.sv]
// Back end: walks the frame at the queue head one pixel per transaction.
// Depends on rsl_pkg for the entry, pixel and configuration types.
module rsl_back (
   input  logic               clock,
   input  logic               reset,
   input  rsl_pkg::cfg_type   cfg,
   input  rsl_pkg::entry_type head,
   input  logic               head_valid,
   input  logic               pop,
   output rsl_pkg::pixel_type pixel,
   output logic               frame_done
);
   import rsl_pkg::*;

   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [PIX_W-1:0] end_gap;
   logic             last;

   always_comb begin
      last       = pix_ff == PIX_W'(PIXEL_COUNT-1);
      frame_done = head_valid && pop && last;
      pix_in     = pix_ff;
      if (head_valid && pop) pix_in = last ? '0 : pix_ff + PIX_W'(1);

      end_gap = (pix_ff < PIX_W'(PIXEL_COUNT-1) - pix_ff) ? pix_ff
              : PIX_W'(PIXEL_COUNT-1) - pix_ff;

      pixel.index = pix_ff;
      pixel.stage = head.stage;
      pixel.last  = last;
      pixel.red   = '0;
      pixel.green = '0;
      pixel.blue  = '0;
      if (head.bar_mode) begin
         if (head.mask[pix_ff]) begin
            if (pix_ff <= PIX_W'(BAR_GREEN_LAST)) begin
               pixel.green = cfg.green_level;
            end else if (pix_ff <= PIX_W'(BAR_YELLOW_LAST)) begin
               pixel.red   = cfg.yellow_red_level;
               pixel.green = cfg.green_level;
            end else begin
               pixel.red   = cfg.red_level;
            end
         end
      end else if (head.lit >= LIT_ALL_BLUE) begin
         pixel.blue = cfg.blue_level;
      end else if (STAGE_W'(end_gap) < head.lit) begin
         if (end_gap <= PIX_W'(SIDE_GREEN_LAST)) begin
            pixel.green = cfg.green_level;
         end else if (end_gap <= PIX_W'(SIDE_YELLOW_LAST)) begin
            pixel.red   = cfg.yellow_red_level;
            pixel.green = cfg.green_level;
         end else begin
            pixel.red   = cfg.red_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff <= '0;
      end else begin
         pix_ff <= pix_in;
      end
   end

endmodule

[test/rpm_shift_light_bar_tb.sv]
// Self-checking bench for the tachometer shift light bar: directed table, then random phases.
// Holds its own prediction of every pixel frame and checks each pixel transaction in order.
// Depends on rsl_pkg and the rpm_shift_light_bar top level only.
module rpm_shift_light_bar_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rsl_pkg::*;

   localparam int LAST_PIXEL       = PIXEL_COUNT - 1;
   localparam int RESET_CYCLES     = 6;
   // a sample with no frame queues nothing, so these spare cycles cover it
   localparam int DRAIN_CYCLES     = 8;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASES           = 10;
   localparam int PHASE_SAMPLES    = 31;
   localparam int MAX_REPORTS      = 200;
   // slowest sane run: ~340 samples of 15 pixels each under the worst receiver stalls,
   // plus gaps and the long hold; the limit allows four times that run
   localparam int CYCLE_LIMIT      = 400000;

   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REGISTER = 3'd7;

   localparam logic [RPM_W-1:0]   RESET_SHIFT_RPM = 16'd5500;
   localparam logic [RPM_W-1:0]   RESET_STEP_RPM  = 16'd300;
   localparam logic [LEVEL_W-1:0] RESET_LEVEL     = 8'hFF;

   typedef enum logic [1:0] {
      FRAME_PREDICTED = 2'd0,
      FRAME_NONE      = 2'd1,
      FRAME_UNIFORM   = 2'd2
   } frame_kind_type;

   typedef enum logic {
      ROW_SAMPLE = 1'b0,
      ROW_WRITE  = 1'b1
   } row_kind_type;

   // frame typed into the directed table; uniform means all 15 pixels alike
   typedef struct packed {
      frame_kind_type     kind;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [STAGE_W-1:0] stage;
   } table_frame_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   value;
      table_frame_type         frame;
   } stim_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   push      = 1'b0;
   logic [RPM_W-1:0]       req_rpm   = '0;
   logic                   pop       = 1'b0;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   logic                   full;
   logic                   empty;
   logic [PIX_W-1:0]       rsp_pixel_index;
   logic [LEVEL_W-1:0]     rsp_red;
   logic [LEVEL_W-1:0]     rsp_green;
   logic [LEVEL_W-1:0]     rsp_blue;
   logic [STAGE_W-1:0]     rsp_stage;
   logic                   rsp_last_pixel;

   // mirror of the block's registers and of its remembered stage
   cfg_type                mirror_cfg;
   logic [STAGE_W-1:0]     mirror_shown_stage;

   pixel_type              frame_buf[$];
   pixel_type              pending_pixels[$];
   table_frame_type        table_frames[$];
   stim_row_type           directed_rows[$];

   int                     error_count = 0;
   int                     cycle_count = 0;
   bit                     idle_on = 1'b0;
   bit                     rsp_hold_request = 1'b0;

   rpm_shift_light_bar uut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_rpm         (req_rpm),
      .empty           (empty),
      .pop             (pop),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue),
      .rsp_stage       (rsp_stage),
      .rsp_last_pixel  (rsp_last_pixel),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   // bar threshold k steps below the shift speed, signed, may go negative
   function automatic int threshold(int k);
      return int'(mirror_cfg.shift_rpm) - k * int'(mirror_cfg.step_rpm);
   endfunction

   function automatic pixel_type make_pixel(int i, logic [LEVEL_W-1:0] r,
                                            logic [LEVEL_W-1:0] g, logic [LEVEL_W-1:0] b,
                                            logic [STAGE_W-1:0] stage);
      pixel_type px;
      px.index = PIX_W'(i);
      px.red   = r;
      px.green = g;
      px.blue  = b;
      px.stage = stage;
      px.last  = (i == LAST_PIXEL);
      return px;
   endfunction

   // symmetric fill: lit pixels from each end, colour by distance to the nearer end
   function automatic void emit_side_frame(logic [STAGE_W-1:0] lit, logic [STAGE_W-1:0] stage);
      int d;
      logic [LEVEL_W-1:0] r, g, b;
      for (int i = 0; i < PIXEL_COUNT; i++) begin
         d = (i < LAST_PIXEL - i) ? i : LAST_PIXEL - i;
         r = '0;
         g = '0;
         b = '0;
         if (lit >= 9) begin
            b = mirror_cfg.blue_level;
         end else if (d < lit) begin
            if (d <= 2) begin
               g = mirror_cfg.green_level;
            end else if (d <= 5) begin
               r = mirror_cfg.yellow_red_level;
               g = mirror_cfg.green_level;
            end else begin
               r = mirror_cfg.red_level;
            end
         end
         frame_buf.push_back(make_pixel(i, r, g, b, stage));
      end
   endfunction

   // work out the frame one speed sample causes; leaves it in frame_buf
   function automatic void predict_frame(logic [RPM_W-1:0] rpm);
      int speed;
      logic [STAGE_W-1:0] stage;
      logic [STAGE_W-1:0] lit;
      logic [LEVEL_W-1:0] r, g;
      speed = int'(rpm);
      frame_buf.delete();
      if (mirror_cfg.display_mode == MODE_LEFT_RIGHT) begin
         for (int i = 0; i < PIXEL_COUNT; i++) begin
            r = '0;
            g = '0;
            if (speed > threshold(LAST_PIXEL - i)) begin
               if (i <= 9) begin
                  g = mirror_cfg.green_level;
               end else if (i <= 12) begin
                  r = mirror_cfg.yellow_red_level;
                  g = mirror_cfg.green_level;
               end else begin
                  r = mirror_cfg.red_level;
               end
            end
            frame_buf.push_back(make_pixel(i, r, g, '0, '0));
         end
         return;
      end
      stage = '0;
      case (mirror_cfg.display_mode)
         MODE_SIDE_FILL: begin
            // walk down so the lowest matching stage wins
            if (speed > threshold(8)) begin
               stage = 4'd9;
               for (int s = 8; s >= 1; s--)
                  if (speed < threshold(8 - s)) stage = STAGE_W'(s);
            end
            lit = stage;
         end
         MODE_SIDE_SHORT: begin
            if (speed > threshold(3)) begin
               stage = 4'd4;
               for (int s = 3; s >= 1; s--)
                  if (speed < threshold(3 - s)) stage = STAGE_W'(s);
            end
            case (stage)
               4'd1:    lit = 4'd3;
               4'd2:    lit = 4'd6;
               4'd3:    lit = 4'd8;
               4'd4:    lit = 4'd9;
               default: lit = 4'd0;
            endcase
         end
         default: begin
            stage = (speed > int'(mirror_cfg.shift_rpm)) ? 4'd1 : 4'd0;
            lit   = (stage != 0) ? 4'd9 : 4'd0;
         end
      endcase
      // quantised modes only redraw when the stage moves
      if (stage != mirror_shown_stage) begin
         mirror_shown_stage = stage;
         emit_side_frame(lit, stage);
      end
   endfunction

   // --------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("MISMATCH @%0t: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [LEVEL_W-1:0] got,
                              input logic [LEVEL_W-1:0] wanted, input logic [PIX_W-1:0] at);
      if (got !== wanted)
         report_mismatch($sformatf("pixel %0d %s: got %0h, expected %0h", at, name, got, wanted));
   endtask

   // Monitor: track register writes, predict on each accepted sample and
   // compare each accepted pixel with the oldest one still outstanding.
   always @(posedge clock) begin : monitor
      pixel_type       want;
      table_frame_type row_frame;
      if (reset) begin
         mirror_cfg.shift_rpm        = RESET_SHIFT_RPM;
         mirror_cfg.step_rpm         = RESET_STEP_RPM;
         mirror_cfg.display_mode     = MODE_SIDE_FILL;
         mirror_cfg.green_level      = RESET_LEVEL;
         mirror_cfg.yellow_red_level = RESET_LEVEL;
         mirror_cfg.red_level        = RESET_LEVEL;
         mirror_cfg.blue_level       = RESET_LEVEL;
         mirror_shown_stage          = '0;
         pending_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SHIFT_RPM:        mirror_cfg.shift_rpm        = csr_data;
               CSR_STEP_RPM:         mirror_cfg.step_rpm         = csr_data;
               CSR_DISPLAY_MODE:     mirror_cfg.display_mode     = mode_type'(csr_data[1:0]);
               CSR_GREEN_LEVEL:      mirror_cfg.green_level      = csr_data[7:0];
               CSR_YELLOW_RED_LEVEL: mirror_cfg.yellow_red_level = csr_data[7:0];
               CSR_RED_LEVEL:        mirror_cfg.red_level        = csr_data[7:0];
               CSR_BLUE_LEVEL:       mirror_cfg.blue_level       = csr_data[7:0];
               default: ;  // unused index: drop the write
            endcase
         end
         // check before predicting, so a pixel can never match its own sample's edge
         if (pop && !empty) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch($sformatf("pixel %0d stage %0d with no sample behind it",
                                         rsp_pixel_index, rsp_stage));
            end else begin
               want = pending_pixels.pop_front();
               check_field("pixel_index", LEVEL_W'(rsp_pixel_index), LEVEL_W'(want.index),
                           want.index);
               check_field("red", rsp_red, want.red, want.index);
               check_field("green", rsp_green, want.green, want.index);
               check_field("blue", rsp_blue, want.blue, want.index);
               check_field("stage", LEVEL_W'(rsp_stage), LEVEL_W'(want.stage), want.index);
               check_field("last_pixel", LEVEL_W'(rsp_last_pixel), LEVEL_W'(want.last),
                           want.index);
            end
         end
         if (push && !full) begin
            predict_frame(req_rpm);
            // directed rows may carry a frame typed in by hand; it overrides
            if (table_frames.size() != 0) begin
               row_frame = table_frames.pop_front();
               if (row_frame.kind != FRAME_PREDICTED) frame_buf.delete();
               if (row_frame.kind == FRAME_UNIFORM)
                  for (int i = 0; i < PIXEL_COUNT; i++)
                     frame_buf.push_back(make_pixel(i, row_frame.red, row_frame.green,
                                                    row_frame.blue, row_frame.stage));
            end
            foreach (frame_buf[j]) pending_pixels.push_back(frame_buf[j]);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic stim_row_type reg_row(logic [CSR_INDEX_W-1:0] index,
                                            logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row = '0;
      row.kind  = ROW_WRITE;
      row.index = index;
      row.value = value;
      row.frame.kind = FRAME_PREDICTED;
      return row;
   endfunction

   function automatic stim_row_type rpm_row(logic [RPM_W-1:0] rpm);
      stim_row_type row;
      row = '0;
      row.kind  = ROW_SAMPLE;
      row.value = rpm;
      row.frame.kind = FRAME_PREDICTED;
      return row;
   endfunction

   function automatic stim_row_type quiet_row(logic [RPM_W-1:0] rpm);
      stim_row_type row;
      row = rpm_row(rpm);
      row.frame.kind = FRAME_NONE;
      return row;
   endfunction

   function automatic stim_row_type flat_row(logic [RPM_W-1:0] rpm, logic [LEVEL_W-1:0] r,
                                             logic [LEVEL_W-1:0] g, logic [LEVEL_W-1:0] b,
                                             logic [STAGE_W-1:0] stage);
      stim_row_type row;
      row = rpm_row(rpm);
      row.frame = '{kind: FRAME_UNIFORM, red: r, green: g, blue: b, stage: stage};
      return row;
   endfunction

   // mostly land within a couple of rpm of some threshold, where stages flip
   function automatic logic [RPM_W-1:0] random_rpm();
      int pick;
      int level;
      pick = $urandom_range(0, 9);
      if (pick == 0) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      if (pick <= 2) return RPM_W'($urandom_range(0, 65535));
      level = threshold(int'($urandom_range(0, 15))) + int'($urandom_range(0, 4)) - 2;
      if (level < 0) level = 0;
      if (level > 65535) level = 65535;
      return RPM_W'(level);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] speed_setting(int unsigned lo, int unsigned hi);
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         5:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(lo, hi));
      endcase
   endfunction

   // random upper byte exercises the masking of the 8-bit registers
   function automatic logic [CSR_DATA_W-1:0] level_setting();
      logic [LEVEL_W-1:0] level;
      case ($urandom_range(0, 3))
         0:       level = 8'h00;
         1:       level = 8'hFF;
         default: level = LEVEL_W'($urandom);
      endcase
      return {8'($urandom), level};
   endfunction

   // Offer one sample and hold it until a transaction takes it; push stays high.
   task automatic send_sample(input logic [RPM_W-1:0] rpm);
      req_rpm <= rpm;
      push    <= 1'b1;
      do @(posedge clock); while (full);
   endtask

   task automatic sender_gap(input int cycles);
      push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop push and hold off until every outstanding pixel has arrived.
   task automatic await_pixels();
      push <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Idle the block fully before touching its registers.
   task automatic settle_block();
      await_pixels();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Raise a write for the next edge; the caller lowers csr_we after the batch.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
   endtask

   // Receiver: random stall bursts, plus one long hold on request so the
   // block fills up and pushes back on the sample side.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            pop <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(0, 16)) @(posedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rpm_shift_light_bar verification failed");
         $finish;
      end
   end

   initial begin : sequencer
      stim_row_type            row;
      bit                      writing;
      logic [CSR_DATA_W-1:0]   shift_value, step_value;
      logic [CSR_DATA_W-1:0]   mode_value;
      logic [CSR_DATA_W-1:0]   green_value, yellow_value, red_value, blue_value;

      // After reset: side fill, shift 5500, step 300, all levels full.
      directed_rows.push_back(quiet_row(16'd0));                         // stage 0 already shown
      directed_rows.push_back(flat_row(16'hFFFF, 8'h00, 8'h00, 8'hFF, 4'd9));
      directed_rows.push_back(quiet_row(16'hFFFF));                      // unchanged stage
      directed_rows.push_back(flat_row(16'd3100, 8'h00, 8'h00, 8'h00, 4'd0)); // on lowest threshold
      directed_rows.push_back(rpm_row(16'd3101));
      directed_rows.push_back(rpm_row(16'd3400));
      directed_rows.push_back(rpm_row(16'd4000));
      directed_rows.push_back(rpm_row(16'd5499));
      directed_rows.push_back(flat_row(16'd5500, 8'h00, 8'h00, 8'hFF, 4'd9)); // shift point
      directed_rows.push_back(reg_row(CSR_DISPLAY_MODE, CSR_DATA_W'(MODE_SIDE_SHORT)));
      directed_rows.push_back(reg_row(CSR_GREEN_LEVEL, 16'h003C));
      directed_rows.push_back(reg_row(CSR_YELLOW_RED_LEVEL, 16'hFFA5));  // upper byte masked
      directed_rows.push_back(reg_row(CSR_RED_LEVEL, 16'h0081));
      directed_rows.push_back(flat_row(16'd0, 8'h00, 8'h00, 8'h00, 4'd0));
      directed_rows.push_back(rpm_row(16'd4700));
      directed_rows.push_back(rpm_row(16'd5000));
      directed_rows.push_back(rpm_row(16'd5300));
      directed_rows.push_back(flat_row(16'hFFFF, 8'h00, 8'h00, 8'hFF, 4'd4));
      directed_rows.push_back(reg_row(CSR_DISPLAY_MODE, 16'hFFFF));      // masks to shift light
      directed_rows.push_back(reg_row(CSR_NO_REGISTER, 16'h0000));       // must change nothing
      directed_rows.push_back(reg_row(CSR_BLUE_LEVEL, 16'h00C3));
      directed_rows.push_back(flat_row(16'd5500, 8'h00, 8'h00, 8'h00, 4'd0)); // equal is not above
      directed_rows.push_back(flat_row(16'd5501, 8'h00, 8'h00, 8'hC3, 4'd1));
      directed_rows.push_back(quiet_row(16'hFFFF));
      directed_rows.push_back(reg_row(CSR_DISPLAY_MODE, CSR_DATA_W'(MODE_LEFT_RIGHT)));
      directed_rows.push_back(flat_row(16'd0, 8'h00, 8'h00, 8'h00, 4'd0));
      directed_rows.push_back(rpm_row(16'hFFFF));
      directed_rows.push_back(rpm_row(16'd2800));
      // negative thresholds, then a flat ladder
      directed_rows.push_back(reg_row(CSR_SHIFT_RPM, 16'h0000));
      directed_rows.push_back(reg_row(CSR_STEP_RPM, 16'hFFFF));
      directed_rows.push_back(reg_row(CSR_DISPLAY_MODE, CSR_DATA_W'(MODE_SIDE_FILL)));
      directed_rows.push_back(rpm_row(16'd0));
      directed_rows.push_back(reg_row(CSR_SHIFT_RPM, 16'hFFFF));
      directed_rows.push_back(reg_row(CSR_STEP_RPM, 16'h0000));
      directed_rows.push_back(rpm_row(16'hFFFF));
      directed_rows.push_back(rpm_row(16'd0));
      directed_rows.push_back(reg_row(CSR_DISPLAY_MODE, CSR_DATA_W'(MODE_LEFT_RIGHT)));
      directed_rows.push_back(rpm_row(16'hFFFE));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the table; writes only once the block has gone quiet.
      writing = 1'b0;
      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         if (row.kind == ROW_WRITE) begin
            if (!writing) begin
               settle_block();
               writing = 1'b1;
            end
            write_register(row.index, row.value);
         end else begin
            if (writing) begin
               csr_we  <= 1'b0;
               writing = 1'b0;
            end
            table_frames.push_back(row.frame);
            send_sample(row.value);
         end
      end

      // Random phases: fresh settings each time, every mode in turn.
      for (int p = 0; p < PHASES; p++) begin
         settle_block();
         idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         shift_value  = speed_setting(1500, 9000);
         step_value   = speed_setting(1, 700);
         green_value  = level_setting();
         yellow_value = level_setting();
         red_value    = level_setting();
         blue_value   = level_setting();
         // force the corners of the settings in two phases
         if (p == 1) begin
            shift_value = 16'h0000;
            step_value  = 16'hFFFF;
            {green_value, yellow_value, red_value, blue_value} = '0;
         end else if (p == 2) begin
            shift_value = 16'hFFFF;
            step_value  = 16'h0000;
            {green_value, yellow_value, red_value, blue_value} = {4{16'h00FF}};
         end
         mode_value = {14'($urandom), 2'(p % 4)};
         write_register(CSR_SHIFT_RPM, shift_value);
         write_register(CSR_STEP_RPM, step_value);
         write_register(CSR_DISPLAY_MODE, mode_value);
         write_register(CSR_GREEN_LEVEL, green_value);
         write_register(CSR_YELLOW_RED_LEVEL, yellow_value);
         write_register(CSR_RED_LEVEL, red_value);
         write_register(CSR_BLUE_LEVEL, blue_value);
         csr_we <= 1'b0;
         // left to right always draws, so the long hold here backs the block up
         if (p == 0) rsp_hold_request = 1'b1;
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            if (p == 3 && n == PHASE_SAMPLES / 2) await_pixels();
            send_sample(random_rpm());
            if (idle_on && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 17));
         end
      end

      // Drain, give the block a few spare cycles, then report.
      await_pixels();
      repeat (4 * DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("rpm_shift_light_bar verification clean");
      else
         $display("rpm_shift_light_bar verification failed");
      $finish;
   end

endmodule

[files.f]
rtl/rsl_pkg.sv
rtl/rsl_front.sv
rtl/rsl_queue.sv
rtl/rsl_back.sv
rtl/rpm_shift_light_bar.sv
test/rpm_shift_light_bar_tb.sv
